// File: design/scbp_pkg.sv
// ----------------------------------------------------------------------------
// scbp_pkg
// shared constants, byte codes and the command record passed front to back
// ----------------------------------------------------------------------------
package scbp_pkg;

    // text frame sizing
    localparam int TEXT_CAPACITY = 64;
    localparam int TEXT_CNT_W    = $clog2(TEXT_CAPACITY);
    localparam int TEXT_INDEX_W  = 6;

    // field widths
    localparam int BYTE_W   = 8;
    localparam int TARGET_W = 15;
    localparam int DIR_W    = 2;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // byte codes
    localparam logic [BYTE_W-1:0] BYTE_LIFT_UP   = 8'h01;
    localparam logic [BYTE_W-1:0] BYTE_LIFT_DOWN = 8'h02;
    localparam logic [BYTE_W-1:0] BYTE_LIFT_STOP = 8'h00;
    localparam logic [BYTE_W-1:0] BYTE_TEXT_OPEN = 8'h24;  // '$'
    localparam logic [BYTE_W-1:0] BYTE_TEXT_CLOSE = 8'h23; // '#'
    localparam logic [BYTE_W-1:0] BYTE_BIN_OPEN  = 8'h0F;
    localparam logic [BYTE_W-1:0] BYTE_BIN_CLOSE = 8'h1F;

    // lift direction codes
    localparam logic signed [DIR_W-1:0] DIR_UP   = 2'sd1;
    localparam logic signed [DIR_W-1:0] DIR_DOWN = -2'sd1;
    localparam logic signed [DIR_W-1:0] DIR_STOP = 2'sd0;

    // decimal weights of the binary frame digits
    localparam int WEIGHT_HUNDREDS = 100;
    localparam int WEIGHT_TENS     = 10;

    // classified byte, one per accepted transfer
    typedef struct packed {
        logic                     lift_valid;
        logic signed [DIR_W-1:0]  lift_dir;
        logic                     target_valid;
        logic [BYTE_W-1:0]        digit0;
        logic [BYTE_W-1:0]        digit1;
        logic [BYTE_W-1:0]        digit2;
        logic                     text_start;
        logic                     text_valid;
        logic [BYTE_W-1:0]        text_byte;
        logic [TEXT_INDEX_W-1:0]  text_index;
        logic                     text_end;
        logic                     text_abort;
    } t_cmd;

endpackage

// File: design/scbp_front.sv
// ----------------------------------------------------------------------------
// scbp_front
// accepts bytes, tracks text and binary frame state, emits one command each
// ----------------------------------------------------------------------------
module scbp_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [scbp_pkg::BYTE_W-1:0]    i_rx_byte,
    input  logic                           i_queue_full,
    output logic                           o_push,
    output scbp_pkg::t_cmd                 o_cmd
);

    // binary frame step codes
    localparam logic [2:0] STEP_IDLE  = 3'd0;
    localparam logic [2:0] STEP_D0    = 3'd1;
    localparam logic [2:0] STEP_D1    = 3'd2;
    localparam logic [2:0] STEP_D2    = 3'd3;
    localparam logic [2:0] STEP_CLOSE = 3'd4;

    logic                                r_in_text;
    logic                                n_in_text;
    logic [scbp_pkg::TEXT_CNT_W-1:0]     r_text_count;
    logic [scbp_pkg::TEXT_CNT_W-1:0]     n_text_count;
    logic [2:0]                          r_step;
    logic [2:0]                          n_step;
    logic [scbp_pkg::BYTE_W-1:0]         r_digit0;
    logic [scbp_pkg::BYTE_W-1:0]         r_digit1;
    logic [scbp_pkg::BYTE_W-1:0]         r_digit2;
    logic [scbp_pkg::BYTE_W-1:0]         n_digit0;
    logic [scbp_pkg::BYTE_W-1:0]         n_digit1;
    logic [scbp_pkg::BYTE_W-1:0]         n_digit2;
    logic                                w_text_full;
    scbp_pkg::t_cmd                      w_cmd;

    assign o_stall     = i_queue_full;
    assign o_push      = i_valid && !i_queue_full;
    assign o_cmd       = w_cmd;
    assign w_text_full = (r_text_count == scbp_pkg::TEXT_CNT_W'(scbp_pkg::TEXT_CAPACITY - 1));

    always_comb begin
        n_in_text    = r_in_text;
        n_text_count = r_text_count;
        n_step       = r_step;
        n_digit0     = r_digit0;
        n_digit1     = r_digit1;
        n_digit2     = r_digit2;
        w_cmd        = '0;

        // lift bytes only count outside any frame
        if (!r_in_text && r_step == STEP_IDLE) begin
            if (i_rx_byte == scbp_pkg::BYTE_LIFT_UP) begin
                w_cmd.lift_valid = 1'b1;
                w_cmd.lift_dir   = scbp_pkg::DIR_UP;
            end else if (i_rx_byte == scbp_pkg::BYTE_LIFT_DOWN) begin
                w_cmd.lift_valid = 1'b1;
                w_cmd.lift_dir   = scbp_pkg::DIR_DOWN;
            end else if (i_rx_byte == scbp_pkg::BYTE_LIFT_STOP) begin
                w_cmd.lift_valid = 1'b1;
                w_cmd.lift_dir   = scbp_pkg::DIR_STOP;
            end
        end

        if (i_rx_byte == scbp_pkg::BYTE_TEXT_OPEN) begin
            // open or restart, binary frame untouched
            n_in_text        = 1'b1;
            n_text_count     = '0;
            w_cmd.text_start = 1'b1;
        end else if (r_in_text) begin
            if (i_rx_byte == scbp_pkg::BYTE_TEXT_CLOSE) begin
                n_in_text      = 1'b0;
                w_cmd.text_end = 1'b1;
            end else if (!w_text_full) begin
                w_cmd.text_valid = 1'b1;
                w_cmd.text_byte  = i_rx_byte;
                w_cmd.text_index = scbp_pkg::TEXT_INDEX_W'(r_text_count);
                n_text_count     = r_text_count + 1'b1;
            end else begin
                n_in_text        = 1'b0;
                w_cmd.text_abort = 1'b1;
            end
        end else begin
            case (r_step)
                STEP_IDLE: begin
                    if (i_rx_byte == scbp_pkg::BYTE_BIN_OPEN) begin
                        n_step = STEP_D0;
                    end
                end
                STEP_D0: begin
                    n_digit0 = i_rx_byte;
                    n_step   = STEP_D1;
                end
                STEP_D1: begin
                    n_digit1 = i_rx_byte;
                    n_step   = STEP_D2;
                end
                STEP_D2: begin
                    n_digit2 = i_rx_byte;
                    n_step   = STEP_CLOSE;
                end
                STEP_CLOSE: begin
                    if (i_rx_byte == scbp_pkg::BYTE_BIN_CLOSE) begin
                        w_cmd.target_valid = 1'b1;
                        w_cmd.digit0       = r_digit0;
                        w_cmd.digit1       = r_digit1;
                        w_cmd.digit2       = r_digit2;
                    end
                    n_step = STEP_IDLE;
                end
                default: begin
                    n_step = STEP_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_text    <= 1'b0;
            r_text_count <= '0;
            r_step       <= STEP_IDLE;
            r_digit0     <= '0;
            r_digit1     <= '0;
            r_digit2     <= '0;
        end else if (o_push) begin
            r_in_text    <= n_in_text;
            r_text_count <= n_text_count;
            r_step       <= n_step;
            r_digit0     <= n_digit0;
            r_digit1     <= n_digit1;
            r_digit2     <= n_digit2;
        end
    end

endmodule

// File: design/scbp_queue.sv
// ----------------------------------------------------------------------------
// scbp_queue
// small command fifo that lets front and back stall independently
// ----------------------------------------------------------------------------
module scbp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  scbp_pkg::t_cmd  i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_not_empty,
    output scbp_pkg::t_cmd  o_cmd
);

    scbp_pkg::t_cmd                      r_entry [scbp_pkg::QUEUE_DEPTH];
    logic [scbp_pkg::QUEUE_PTR_W-1:0]    r_wr_ptr;
    logic [scbp_pkg::QUEUE_PTR_W-1:0]    r_rd_ptr;
    logic [scbp_pkg::QUEUE_CNT_W-1:0]    r_count;
    logic [scbp_pkg::QUEUE_CNT_W-1:0]    n_count;

    assign o_full      = (r_count == scbp_pkg::QUEUE_CNT_W'(scbp_pkg::QUEUE_DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_cmd       = r_entry[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    // payload storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// File: design/scbp_back.sv
// ----------------------------------------------------------------------------
// scbp_back
// decodes binary frame value and holds the result in the output register
// ----------------------------------------------------------------------------
module scbp_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_not_empty,
    input  scbp_pkg::t_cmd                        i_cmd,
    output logic                                  o_pop,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic                                  o_lift_valid,
    output logic signed [scbp_pkg::DIR_W-1:0]     o_lift_dir,
    output logic                                  o_target_valid,
    output logic [scbp_pkg::TARGET_W-1:0]         o_target_value,
    output logic                                  o_text_start,
    output logic                                  o_text_valid,
    output logic [scbp_pkg::BYTE_W-1:0]           o_text_byte,
    output logic [scbp_pkg::TEXT_INDEX_W-1:0]     o_text_index,
    output logic                                  o_text_end,
    output logic                                  o_text_abort
);

    logic                                  r_valid;
    logic                                  r_lift_valid;
    logic signed [scbp_pkg::DIR_W-1:0]     r_lift_dir;
    logic                                  r_target_valid;
    logic [scbp_pkg::TARGET_W-1:0]         r_target_value;
    logic                                  r_text_start;
    logic                                  r_text_valid;
    logic [scbp_pkg::BYTE_W-1:0]           r_text_byte;
    logic [scbp_pkg::TEXT_INDEX_W-1:0]     r_text_index;
    logic                                  r_text_end;
    logic                                  r_text_abort;
    logic [scbp_pkg::TARGET_W-1:0]         w_d0;
    logic [scbp_pkg::TARGET_W-1:0]         w_d1;
    logic [scbp_pkg::TARGET_W-1:0]         w_d2;
    logic [scbp_pkg::TARGET_W-1:0]         n_target_value;

    // load when the register is empty or being drained this cycle
    assign o_pop = i_not_empty && (!r_valid || !i_stall);

    // digits are zero unless the frame completed
    assign w_d0 = scbp_pkg::TARGET_W'(i_cmd.digit0);
    assign w_d1 = scbp_pkg::TARGET_W'(i_cmd.digit1);
    assign w_d2 = scbp_pkg::TARGET_W'(i_cmd.digit2);
    assign n_target_value = w_d0 * scbp_pkg::TARGET_W'(scbp_pkg::WEIGHT_HUNDREDS)
                          + w_d1 * scbp_pkg::TARGET_W'(scbp_pkg::WEIGHT_TENS)
                          + w_d2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_lift_valid   <= i_cmd.lift_valid;
            r_lift_dir     <= i_cmd.lift_dir;
            r_target_valid <= i_cmd.target_valid;
            r_target_value <= n_target_value;
            r_text_start   <= i_cmd.text_start;
            r_text_valid   <= i_cmd.text_valid;
            r_text_byte    <= i_cmd.text_byte;
            r_text_index   <= i_cmd.text_index;
            r_text_end     <= i_cmd.text_end;
            r_text_abort   <= i_cmd.text_abort;
        end
    end

    assign o_valid        = r_valid;
    assign o_lift_valid   = r_lift_valid;
    assign o_lift_dir     = r_lift_dir;
    assign o_target_valid = r_target_valid;
    assign o_target_value = r_target_value;
    assign o_text_start   = r_text_start;
    assign o_text_valid   = r_text_valid;
    assign o_text_byte    = r_text_byte;
    assign o_text_index   = r_text_index;
    assign o_text_end     = r_text_end;
    assign o_text_abort   = r_text_abort;

endmodule

// File: design/serial_command_byte_parser.sv
// ----------------------------------------------------------------------------
// serial_command_byte_parser
// splits a serial byte stream into lift, text frame and binary frame results
// ----------------------------------------------------------------------------
// path: each accepted byte is registered in the command queue and then in the
// output register, where o_valid shows it
// throughput: one byte per cycle while o_stall is low, set by the front's state update
// a 4-entry command queue absorbs output stalls; o_stall rises when it is full
// reset (synchronous, i_rst_n low) closes any text or binary frame, zeroes
// the stored digits, empties the queue and drops the output register
// ----------------------------------------------------------------------------
module serial_command_byte_parser (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input channel
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [scbp_pkg::BYTE_W-1:0]           i_rx_byte,
    // output channel
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic                                  o_lift_valid,
    output logic signed [scbp_pkg::DIR_W-1:0]     o_lift_dir,
    output logic                                  o_target_valid,
    output logic [scbp_pkg::TARGET_W-1:0]         o_target_value,
    output logic                                  o_text_start,
    output logic                                  o_text_valid,
    output logic [scbp_pkg::BYTE_W-1:0]           o_text_byte,
    output logic [scbp_pkg::TEXT_INDEX_W-1:0]     o_text_index,
    output logic                                  o_text_end,
    output logic                                  o_text_abort
);

    // front to queue
    logic            w_push;
    logic            w_full;
    scbp_pkg::t_cmd  w_front_cmd;

    // queue to back
    logic            w_pop;
    logic            w_not_empty;
    scbp_pkg::t_cmd  w_head_cmd;

    // front: owns all frame state, so each byte is classified in the cycle
    // of its transfer and the next byte can follow right away
    scbp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_rx_byte    (i_rx_byte),
        .i_queue_full (w_full),
        .o_push       (w_push),
        .o_cmd        (w_front_cmd)
    );

    // queue: decouples the front from stalls on the output side
    scbp_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_cmd       (w_front_cmd),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_not_empty (w_not_empty),
        .o_cmd       (w_head_cmd)
    );

    // back: forms the decimal target value and drives the output register
    scbp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_not_empty    (w_not_empty),
        .i_cmd          (w_head_cmd),
        .o_pop          (w_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_lift_valid   (o_lift_valid),
        .o_lift_dir     (o_lift_dir),
        .o_target_valid (o_target_valid),
        .o_target_value (o_target_value),
        .o_text_start   (o_text_start),
        .o_text_valid   (o_text_valid),
        .o_text_byte    (o_text_byte),
        .o_text_index   (o_text_index),
        .o_text_end     (o_text_end),
        .o_text_abort   (o_text_abort)
    );

endmodule

// File: design/scbp_checker.sv
// ----------------------------------------------------------------------------
// scbp_checker
// port-level checks on the parser, attached by bind
// ----------------------------------------------------------------------------
module scbp_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  o_valid,
    input  logic                                  i_stall,
    input  logic                                  o_lift_valid,
    input  logic signed [scbp_pkg::DIR_W-1:0]     o_lift_dir,
    input  logic                                  o_target_valid,
    input  logic [scbp_pkg::TARGET_W-1:0]         o_target_value,
    input  logic                                  o_text_start,
    input  logic                                  o_text_valid,
    input  logic [scbp_pkg::BYTE_W-1:0]           o_text_byte,
    input  logic [scbp_pkg::TEXT_INDEX_W-1:0]     o_text_index,
    input  logic                                  o_text_end,
    input  logic                                  o_text_abort
);

    // a stalled result stays offered
    a_hold_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // reset empties the output register
    a_reset_clears : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result shown right after reset");

    // one byte causes at most one kind of event
    a_one_event : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $countones({o_lift_valid, o_target_valid, o_text_start,
                                o_text_valid, o_text_end, o_text_abort}) <= 1)
        else $error("more than one event flag in a result");

    // stored text stays inside the frame capacity and idle fields read zero
    a_text_fields : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_text_valid ?
            (32'(o_text_index) < scbp_pkg::TEXT_CAPACITY - 1) :
            (o_text_byte == '0 && o_text_index == '0)))
        else $error("text fields out of range");

    // value and direction read zero when their flags are low
    a_idle_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_target_valid || o_target_value == '0) &&
                    (o_lift_valid || o_lift_dir == scbp_pkg::DIR_STOP))
        else $error("payload set without its flag");

endmodule

bind serial_command_byte_parser scbp_checker u_scbp_checker (.*);

// File: dv/serial_command_byte_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_command_byte_parser_test
// self-checking bench: feeds lift bytes, text frames and binary frames
// through the parser under random input gaps and output stalls, predicts
// every result in the bench and compares each output transfer field by field
// ----------------------------------------------------------------------------
module serial_command_byte_parser_test;

    localparam int CLK_HALF     = 6;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 800;
    localparam int MAX_REPORTS  = 10;
    localparam int SETTLE_CYCLES = 8;     // quiet time after the last expected result

    // one result as the outputs present it
    typedef struct packed {
        logic                                lift_valid;
        logic signed [scbp_pkg::DIR_W-1:0]   lift_dir;
        logic                                target_valid;
        logic [scbp_pkg::TARGET_W-1:0]       target_value;
        logic                                text_start;
        logic                                text_valid;
        logic [scbp_pkg::BYTE_W-1:0]         text_byte;
        logic [scbp_pkg::TEXT_INDEX_W-1:0]   text_index;
        logic                                text_end;
        logic                                text_abort;
    } t_parse_result;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PATTERN
    } t_stall_mode;

    // ------------------------------------------------------------------
    // dut ports
    // ------------------------------------------------------------------
    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 i_valid;
    logic                                 o_stall;
    logic [scbp_pkg::BYTE_W-1:0]          i_rx_byte;
    logic                                 o_valid;
    logic                                 i_stall;
    logic                                 o_lift_valid;
    logic signed [scbp_pkg::DIR_W-1:0]    o_lift_dir;
    logic                                 o_target_valid;
    logic [scbp_pkg::TARGET_W-1:0]        o_target_value;
    logic                                 o_text_start;
    logic                                 o_text_valid;
    logic [scbp_pkg::BYTE_W-1:0]          o_text_byte;
    logic [scbp_pkg::TEXT_INDEX_W-1:0]    o_text_index;
    logic                                 o_text_end;
    logic                                 o_text_abort;

    serial_command_byte_parser dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_lift_valid   (o_lift_valid),
        .o_lift_dir     (o_lift_dir),
        .o_target_valid (o_target_valid),
        .o_target_value (o_target_value),
        .o_text_start   (o_text_start),
        .o_text_valid   (o_text_valid),
        .o_text_byte    (o_text_byte),
        .o_text_index   (o_text_index),
        .o_text_end     (o_text_end),
        .o_text_abort   (o_text_abort)
    );

    // ------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------
    t_parse_result  expected_results[$];   // predictions waiting for a transfer

    // parser state as the bench tracks it
    logic                         text_open;
    int                           text_fill;
    logic [2:0]                   bin_step;
    logic [scbp_pkg::BYTE_W-1:0]  bin_digit [3];

    // sender shaping
    int                 burst_left;
    int                 gap_max;
    int                 bytes_sent;

    // receiver shaping
    t_stall_mode        stall_mode;
    logic [15:0]        stall_pattern;
    int                 pattern_pos;
    int                 hold_left;          // long receiver hold-off, in cycles

    // scoreboard counters
    int                 mismatches;
    int                 unexpected;
    int                 results_seen;
    int                 lifts_seen;
    int                 targets_seen;
    int                 frames_closed;
    int                 frames_aborted;
    int                 cycle_count;

    // ------------------------------------------------------------------
    // clock and watchdog
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // a hung handshake ends the run here
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // prediction: one call per accepted input transfer
    // ------------------------------------------------------------------
    function automatic t_parse_result predict_parse(input logic [scbp_pkg::BYTE_W-1:0] b);
        t_parse_result r;
        int            sum;
        r = '0;

        // lift bytes only count while no frame of either kind is open
        if (!text_open && bin_step == 3'd0) begin
            if (b == scbp_pkg::BYTE_LIFT_UP) begin
                r.lift_valid = 1'b1;
                r.lift_dir   = scbp_pkg::DIR_UP;
            end else if (b == scbp_pkg::BYTE_LIFT_DOWN) begin
                r.lift_valid = 1'b1;
                r.lift_dir   = scbp_pkg::DIR_DOWN;
            end else if (b == scbp_pkg::BYTE_LIFT_STOP) begin
                r.lift_valid = 1'b1;
                r.lift_dir   = scbp_pkg::DIR_STOP;
            end
        end

        if (b == scbp_pkg::BYTE_TEXT_OPEN) begin
            // opens or restarts text, a pending binary frame is left alone
            text_open    = 1'b1;
            text_fill    = 0;
            r.text_start = 1'b1;
        end else if (text_open) begin
            if (b == scbp_pkg::BYTE_TEXT_CLOSE) begin
                text_open  = 1'b0;
                r.text_end = 1'b1;
            end else if (text_fill < scbp_pkg::TEXT_CAPACITY - 1) begin
                r.text_valid = 1'b1;
                r.text_byte  = b;
                r.text_index = scbp_pkg::TEXT_INDEX_W'(text_fill);
                text_fill++;
            end else begin
                // frame is full: drop the byte and the frame
                text_open    = 1'b0;
                r.text_abort = 1'b1;
            end
        end else if (b == scbp_pkg::BYTE_BIN_OPEN && bin_step == 3'd0) begin
            bin_step = 3'd1;
        end else if (bin_step >= 3'd1 && bin_step <= 3'd3) begin
            bin_digit[bin_step - 3'd1] = b;
            bin_step++;
        end else if (bin_step == 3'd4 && b == scbp_pkg::BYTE_BIN_CLOSE) begin
            sum = int'(bin_digit[0]) * scbp_pkg::WEIGHT_HUNDREDS
                + int'(bin_digit[1]) * scbp_pkg::WEIGHT_TENS
                + int'(bin_digit[2]);
            r.target_valid = 1'b1;
            r.target_value = sum[scbp_pkg::TARGET_W-1:0];
            bin_step       = 3'd0;
        end else if (bin_step != 3'd0) begin
            // wrong closing byte cancels and is not looked at again
            bin_step = 3'd0;
        end
        return r;
    endfunction

    function automatic string describe(input t_parse_result r);
        return $sformatf({"lift %0b/%0d target %0b/%0d start %0b text %0b/%02h@%0d ",
                          "end %0b abort %0b"},
                         r.lift_valid, r.lift_dir, r.target_valid, r.target_value,
                         r.text_start, r.text_valid, r.text_byte, r.text_index,
                         r.text_end, r.text_abort);
    endfunction

    // ------------------------------------------------------------------
    // sender: one byte per call, bursts with random gaps between them
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [scbp_pkg::BYTE_W-1:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (gap_max > 0) begin
                gap = $urandom_range(0, gap_max);
                if (gap > 0) begin
                    @(negedge i_clk);
                    i_valid <= 1'b0;
                    repeat (gap - 1) @(negedge i_clk);
                end
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        // hold the payload until the transfer happens
        do @(posedge i_clk); while (o_stall);
        expected_results.push_back(predict_parse(b));
        bytes_sent++;
    endtask

    // sender goes quiet until every predicted result has come out
    task automatic wait_all_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [scbp_pkg::BYTE_W-1:0] random_text_char();
        logic [scbp_pkg::BYTE_W-1:0] c;
        do c = scbp_pkg::BYTE_W'($urandom_range(0, 255));
        while (c == scbp_pkg::BYTE_TEXT_OPEN || c == scbp_pkg::BYTE_TEXT_CLOSE);
        return c;
    endfunction

    // ------------------------------------------------------------------
    // receiver: stall pattern plus an optional long hold-off
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        pattern_pos <= pattern_pos + 1;
        if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            case (stall_mode)
                STALL_NONE:    i_stall <= 1'b0;
                STALL_RANDOM:  i_stall <= ($urandom_range(0, 3) == 0);
                STALL_PATTERN: i_stall <= stall_pattern[pattern_pos % 16];
                default:       i_stall <= 1'b0;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // checker: every output transfer against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_parse_result got;
        t_parse_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_lift_valid, o_lift_dir, o_target_valid, o_target_value,
                    o_text_start, o_text_valid, o_text_byte, o_text_index,
                    o_text_end, o_text_abort};
            results_seen++;
            if (expected_results.size() == 0) begin
                unexpected++;
                if (mismatches + unexpected <= MAX_REPORTS)
                    $display("[%0t] result with nothing expected: %s",
                             $realtime, describe(got));
            end else begin
                want = expected_results.pop_front();
                if (want.lift_valid)   lifts_seen++;
                if (want.target_valid) targets_seen++;
                if (want.text_end)     frames_closed++;
                if (want.text_abort)   frames_aborted++;
                if (got.lift_valid   !== want.lift_valid   ||
                    got.lift_dir     !== want.lift_dir     ||
                    got.target_valid !== want.target_valid ||
                    got.target_value !== want.target_value ||
                    got.text_start   !== want.text_start   ||
                    got.text_valid   !== want.text_valid   ||
                    got.text_byte    !== want.text_byte    ||
                    got.text_index   !== want.text_index   ||
                    got.text_end     !== want.text_end     ||
                    got.text_abort   !== want.text_abort) begin
                    mismatches++;
                    if (mismatches + unexpected <= MAX_REPORTS) begin
                        $display("[%0t] mismatch on result %0d", $realtime, results_seen);
                        $display("    expected %s", describe(want));
                        $display("    actual   %s", describe(got));
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // test tasks
    // ------------------------------------------------------------------

    // the three lift codes outside any frame, plus bytes next to them
    task automatic test_lift_commands();
        stall_mode = STALL_NONE;
        gap_max    = 0;
        send_byte(scbp_pkg::BYTE_LIFT_UP);
        send_byte(scbp_pkg::BYTE_LIFT_DOWN);
        send_byte(scbp_pkg::BYTE_LIFT_STOP);
        send_byte(8'h03);
        send_byte(8'hFF);
        wait_all_results();
    endtask

    // open, store, restart, close; hash outside a frame is an ordinary byte
    task automatic test_text_frames();
        stall_mode = STALL_RANDOM;
        gap_max    = 2;
        send_byte(scbp_pkg::BYTE_TEXT_OPEN);
        send_byte(8'h41);
        send_byte(scbp_pkg::BYTE_LIFT_UP);      // lift byte inside text is just text
        send_byte(8'hFF);
        send_byte(scbp_pkg::BYTE_TEXT_OPEN);    // restart resets the index
        send_byte(8'h42);
        send_byte(scbp_pkg::BYTE_TEXT_CLOSE);
        send_byte(scbp_pkg::BYTE_TEXT_CLOSE);   // no frame open now
        send_byte(scbp_pkg::BYTE_LIFT_STOP);
        wait_all_results();
    endtask

    // value extremes, lift codes and frame bytes as digits, bad closer,
    // and a text frame nested inside a pending binary frame
    task automatic test_binary_frames();
        stall_mode    = STALL_PATTERN;
        stall_pattern = 16'b1010_0011_0000_1101;
        gap_max       = 3;
        send_byte(scbp_pkg::BYTE_BIN_OPEN);
        send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFF);
        send_byte(scbp_pkg::BYTE_BIN_CLOSE);
        send_byte(scbp_pkg::BYTE_BIN_OPEN);
        send_byte(8'h00); send_byte(8'h00); send_byte(8'h00);
        send_byte(scbp_pkg::BYTE_BIN_CLOSE);
        send_byte(scbp_pkg::BYTE_BIN_OPEN);
        send_byte(scbp_pkg::BYTE_LIFT_UP); send_byte(scbp_pkg::BYTE_LIFT_DOWN);
        send_byte(scbp_pkg::BYTE_LIFT_STOP); send_byte(scbp_pkg::BYTE_BIN_CLOSE);
        send_byte(scbp_pkg::BYTE_BIN_OPEN);
        send_byte(scbp_pkg::BYTE_BIN_OPEN); send_byte(scbp_pkg::BYTE_BIN_CLOSE);
        send_byte(scbp_pkg::BYTE_TEXT_CLOSE); send_byte(scbp_pkg::BYTE_BIN_CLOSE);
        // wrong closer that is itself an opener, then a lift that must count
        send_byte(scbp_pkg::BYTE_BIN_OPEN);
        send_byte(8'h01); send_byte(8'h02); send_byte(8'h03);
        send_byte(scbp_pkg::BYTE_BIN_OPEN); send_byte(scbp_pkg::BYTE_LIFT_DOWN);
        // dollar during a binary frame keeps the digits collected so far
        send_byte(scbp_pkg::BYTE_BIN_OPEN); send_byte(8'h05);
        send_byte(scbp_pkg::BYTE_TEXT_OPEN);
        send_byte(8'h78); send_byte(scbp_pkg::BYTE_TEXT_CLOSE);
        send_byte(8'h06); send_byte(8'h07);
        send_byte(scbp_pkg::BYTE_BIN_CLOSE);
        wait_all_results();
    endtask

    // frames that reach the capacity, end in each possible way
    task automatic test_text_overflow();
        int i;
        int ending;
        stall_mode = STALL_RANDOM;
        gap_max    = 1;
        for (ending = 0; ending < 3; ending++) begin
            send_byte(scbp_pkg::BYTE_TEXT_OPEN);
            for (i = 0; i < scbp_pkg::TEXT_CAPACITY - 1; i++)
                send_byte(random_text_char());
            case (ending)
                0: send_byte(8'h55);                     // overflow: dropped, frame closed
                1: send_byte(scbp_pkg::BYTE_TEXT_CLOSE); // full frame still closes
                default: begin
                    send_byte(scbp_pkg::BYTE_TEXT_OPEN); // restart at full
                    send_byte(scbp_pkg::BYTE_TEXT_CLOSE);
                end
            endcase
            send_byte(scbp_pkg::BYTE_LIFT_UP);
        end
        wait_all_results();
    endtask

    // receiver holds off long enough for the queue to fill and stall the input
    task automatic test_full_queue();
        int i;
        stall_mode = STALL_NONE;
        gap_max    = 0;
        hold_left  = 300;
        for (i = 0; i < 40; i++)
            send_byte(scbp_pkg::BYTE_W'($urandom_range(0, 255)));
        wait_all_results();
    endtask

    // mostly well-formed traffic with random content, some noise
    task automatic test_random_traffic(input int n_items);
        int kind;
        int len;
        int i;
        int stop_at;
        int next_shuffle;
        logic [scbp_pkg::BYTE_W-1:0] ending;
        stop_at      = bytes_sent + n_items;
        next_shuffle = bytes_sent;
        while (bytes_sent < stop_at) begin
            // new receiver pattern and sender gaps every so often
            if (bytes_sent >= next_shuffle) begin
                next_shuffle  = bytes_sent + 128;
                stall_mode    = t_stall_mode'($urandom_range(0, 2));
                stall_pattern = 16'($urandom());
                gap_max       = $urandom_range(0, 6);
            end
            kind = $urandom_range(0, 99);
            if (kind < 15) begin
                case ($urandom_range(0, 2))
                    0: send_byte(scbp_pkg::BYTE_LIFT_UP);
                    1: send_byte(scbp_pkg::BYTE_LIFT_DOWN);
                    default: send_byte(scbp_pkg::BYTE_LIFT_STOP);
                endcase
            end else if (kind < 55) begin
                case ($urandom_range(0, 19))
                    0:        len = $urandom_range(scbp_pkg::TEXT_CAPACITY - 2,
                                                   scbp_pkg::TEXT_CAPACITY + 6);
                    1, 2, 3:  len = $urandom_range(11, scbp_pkg::TEXT_CAPACITY - 2);
                    default:  len = $urandom_range(0, 10);
                endcase
                send_byte(scbp_pkg::BYTE_TEXT_OPEN);
                for (i = 0; i < len; i++)
                    send_byte(random_text_char());
                case ($urandom_range(0, 9))
                    0, 1:    send_byte(scbp_pkg::BYTE_TEXT_OPEN);   // restart, left open
                    2:       ;                                       // left open
                    default: send_byte(scbp_pkg::BYTE_TEXT_CLOSE);
                endcase
            end else if (kind < 85) begin
                send_byte(scbp_pkg::BYTE_BIN_OPEN);
                for (i = 0; i < 3; i++) begin
                    if ($urandom_range(0, 3) == 0)
                        send_byte(scbp_pkg::BYTE_W'($urandom_range(0, 9)));
                    else
                        send_byte(scbp_pkg::BYTE_W'($urandom_range(0, 255)));
                end
                if ($urandom_range(0, 4) == 0)
                    ending = scbp_pkg::BYTE_W'($urandom_range(0, 255));
                else
                    ending = scbp_pkg::BYTE_BIN_CLOSE;
                send_byte(ending);
            end else begin
                send_byte(scbp_pkg::BYTE_W'($urandom_range(0, 255)));
            end
        end
        wait_all_results();
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_rx_byte      = '0;
        i_stall        = 1'b0;
        text_open      = 1'b0;
        text_fill      = 0;
        bin_step       = 3'd0;
        bin_digit[0]   = '0;
        bin_digit[1]   = '0;
        bin_digit[2]   = '0;
        burst_left     = 0;
        gap_max        = 0;
        bytes_sent     = 0;
        stall_mode     = STALL_NONE;
        stall_pattern  = '0;
        pattern_pos    = 0;
        hold_left      = 0;
        mismatches     = 0;
        unexpected     = 0;
        results_seen   = 0;
        lifts_seen     = 0;
        targets_seen   = 0;
        frames_closed  = 0;
        frames_aborted = 0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_lift_commands();
        test_text_frames();
        test_binary_frames();
        test_text_overflow();
        test_full_queue();
        test_random_traffic(RANDOM_ITEMS);

        $display("run covered %0d bytes in, %0d results out: %0d lift commands, %0d targets",
                 bytes_sent, results_seen, lifts_seen, targets_seen);
        $display("text frames closed %0d, aborted on overflow %0d; mismatches %0d, extra %0d",
                 frames_closed, frames_aborted, mismatches, unexpected);

        if (mismatches == 0 && unexpected == 0 && expected_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/scbp_pkg.sv
design/scbp_front.sv
design/scbp_queue.sv
design/scbp_back.sv
design/serial_command_byte_parser.sv
design/scbp_checker.sv
dv/serial_command_byte_parser_test.sv
